@@ rtl/core/gamepad_serial_poll_encoder_macros.svh @@
// ----------------------------------------------------------------------------
// gamepad serial poll encoder assertion macros
// shared concurrent assertion forms for the rtl
// ----------------------------------------------------------------------------
`ifndef GAMEPAD_SERIAL_POLL_ENCODER_MACROS_SVH
`define GAMEPAD_SERIAL_POLL_ENCODER_MACROS_SVH

// condition must never hold outside reset
`define GSPE_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define GSPE_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define GSPE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/gspe_pkg.sv @@
// ----------------------------------------------------------------------------
// gspe_pkg
// types, constants and the button code map of the gamepad poll encoder
// ----------------------------------------------------------------------------
package gspe_pkg;

    localparam int ButtonBits = 16;
    localparam int BitIdxW    = $clog2(ButtonBits);
    localparam int BitCntW    = $clog2(ButtonBits + 1);
    localparam int PollW      = 16;
    localparam int LenW       = 8;
    localparam int CodeW      = 5;
    localparam int CfgIdxW    = 2;
    localparam int CfgDataW   = 16;

    localparam logic [PollW-1:0]      PollPeriodReset = 16'd50000;
    localparam logic [LenW-1:0]       LatchReset      = 8'd12;
    localparam logic [LenW-1:0]       HalfReset       = 8'd6;
    localparam logic [ButtonBits-1:0] LastWordReset   = ButtonBits'(32'h1111);
    localparam logic [LenW-1:0]       CountMax        = '1;

    localparam logic [ButtonBits-1:0] WordNone  = '0;
    localparam logic [ButtonBits-1:0] WordBtnA  = ButtonBits'(32'h0020);
    localparam logic [ButtonBits-1:0] WordBtnB  = ButtonBits'(32'h0040);
    localparam logic [ButtonBits-1:0] WordBtnC  = ButtonBits'(32'h0080);

    localparam logic [CodeW-1:0] CodeNone  = 5'd0;
    localparam logic [CodeW-1:0] CodeBtnA  = 5'd2;
    localparam logic [CodeW-1:0] CodeBtnB  = 5'd3;
    localparam logic [CodeW-1:0] CodeBtnC  = 5'd4;
    localparam logic [CodeW-1:0] CodeOther = 5'h11;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_POLL_PERIOD = 2'd0,
        CFG_LATCH       = 2'd1,
        CFG_HALF        = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_LATCH = 3'd1,
        PH_GAP   = 3'd2,
        PH_HIGH  = 3'd3,
        PH_LOW   = 3'd4
    } t_phase;

    typedef struct packed {
        logic data_pin;
        logic tx_ready;
    } t_in_item;

    typedef struct packed {
        logic             latch_out;
        logic             clock_out;
        logic             send_valid;
        logic [CodeW-1:0] send_code;
    } t_out_item;

    function automatic logic [CodeW-1:0] code_of(input logic [ButtonBits-1:0] w);
        logic [CodeW-1:0] c;
        if (w == WordNone) begin
            c = CodeNone;
        end else if (w == WordBtnA) begin
            c = CodeBtnA;
        end else if (w == WordBtnB) begin
            c = CodeBtnB;
        end else if (w == WordBtnC) begin
            c = CodeBtnC;
        end else begin
            c = CodeOther;
        end
        return c;
    endfunction

endpackage

@@ rtl/core/gspe_poll_seq.sv @@
// ----------------------------------------------------------------------------
// gspe_poll_seq
// per-tick poll sequencer: latch and clock timing, bit capture, code mapping
// ----------------------------------------------------------------------------
`include "gamepad_serial_poll_encoder_macros.svh"

module gspe_poll_seq (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [gspe_pkg::CfgIdxW-1:0]    i_cfg_idx,
    input  logic [gspe_pkg::CfgDataW-1:0]   i_cfg_data,
    input  logic                            i_step,
    input  gspe_pkg::t_in_item              i_item,
    output gspe_pkg::t_out_item             o_result
);
    import gspe_pkg::*;

    logic [PollW-1:0]      r_poll_period;
    logic [LenW-1:0]       r_latch_len;
    logic [LenW-1:0]       r_half_len;

    t_phase                r_phase, n_phase;
    logic [PollW-1:0]      r_poll_count, n_poll_count;
    logic [LenW-1:0]       r_phase_count, n_phase_count;
    logic [BitCntW-1:0]    r_bit_index, n_bit_index;
    logic [ButtonBits-1:0] r_shift_word, n_shift_word;
    logic [ButtonBits-1:0] r_last_word, n_last_word;

    logic                  due;
    logic [LenW-1:0]       phase_len;
    t_out_item             result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poll_period <= PollPeriodReset;
            r_latch_len   <= LatchReset;
            r_half_len    <= HalfReset;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_POLL_PERIOD: r_poll_period <= i_cfg_data[PollW-1:0];
                CFG_LATCH:       r_latch_len   <= i_cfg_data[LenW-1:0];
                CFG_HALF:        r_half_len    <= i_cfg_data[LenW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_poll_count  <= '0;
            r_phase_count <= '0;
            r_bit_index   <= '0;
            r_shift_word  <= '0;
            r_last_word   <= LastWordReset;
        end else if (i_step) begin
            r_phase       <= n_phase;
            r_poll_count  <= n_poll_count;
            r_phase_count <= n_phase_count;
            r_bit_index   <= n_bit_index;
            r_shift_word  <= n_shift_word;
            r_last_word   <= n_last_word;
        end
    end

    assign due       = ({1'b0, r_poll_count} + 17'd1) >= {1'b0, r_poll_period};
    assign phase_len = (r_phase == PH_LATCH) ? r_latch_len : r_half_len;

    always_comb begin
        n_phase           = r_phase;
        n_poll_count      = r_poll_count;
        n_phase_count     = r_phase_count;
        n_bit_index       = r_bit_index;
        n_shift_word      = r_shift_word;
        n_last_word       = r_last_word;
        result            = '0;

        if (r_phase != PH_IDLE && r_phase_count >= phase_len) begin
            n_phase_count = '0;
            case (r_phase)
                PH_LATCH: begin
                    n_phase = PH_GAP;
                end
                PH_GAP: begin
                    n_phase = PH_HIGH;
                    if (!i_item.data_pin) begin
                        n_shift_word[r_bit_index[BitIdxW-1:0]] = 1'b1;
                    end
                end
                PH_HIGH: begin
                    n_phase = PH_LOW;
                end
                PH_LOW: begin
                    n_bit_index = r_bit_index + 1'b1;
                    if (n_bit_index >= BitCntW'(ButtonBits)) begin
                        if (r_shift_word != r_last_word && i_item.tx_ready) begin
                            result.send_valid = 1'b1;
                            result.send_code  = code_of(r_shift_word);
                        end
                        n_last_word = r_shift_word;
                        n_phase     = PH_IDLE;
                    end else begin
                        n_phase = PH_HIGH;
                        if (!i_item.data_pin) begin
                            n_shift_word[n_bit_index[BitIdxW-1:0]] = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end

        if (n_phase == PH_IDLE && due) begin
            n_phase       = PH_LATCH;
            n_phase_count = '0;
            n_bit_index   = '0;
            n_shift_word  = '0;
            n_poll_count  = '0;
        end else if (!due) begin
            n_poll_count = r_poll_count + 1'b1;
        end

        result.latch_out = (n_phase == PH_LATCH);
        result.clock_out = (n_phase == PH_HIGH);

        if (n_phase != PH_IDLE && n_phase_count < CountMax) begin
            n_phase_count = n_phase_count + 1'b1;
        end
    end

    assign o_result = result;

    `GSPE_ASSERT_NEVER(a_lines_exclusive, i_clk, i_rst_n, result.latch_out && result.clock_out, "latch and clock high together")
    `GSPE_ASSERT_SAME(a_code_needs_valid, i_clk, i_rst_n, result.send_code != CodeNone, result.send_valid, "code without valid")
    `GSPE_ASSERT_NEXT(a_last_word_update, i_clk, i_rst_n, i_step && result.send_valid, r_last_word == $past(r_shift_word), "remembered word not updated")
    `GSPE_ASSERT_NEVER(a_bit_index_range, i_clk, i_rst_n, r_bit_index > BitCntW'(ButtonBits), "bit index out of range")

endmodule

@@ rtl/core/gspe_out_skid.sv @@
// ----------------------------------------------------------------------------
// gspe_out_skid
// result register with one skid entry between the sequencer and the consumer
// ----------------------------------------------------------------------------
module gspe_out_skid (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  gspe_pkg::t_out_item   i_data,
    output logic                  o_stall,
    output logic                  o_valid,
    output gspe_pkg::t_out_item   o_data,
    input  logic                  i_stall
);
    import gspe_pkg::*;

    logic      r_out_valid, n_out_valid;
    logic      r_skid_valid, n_skid_valid;
    t_out_item r_out_data, n_out_data;
    t_out_item r_skid_data, n_skid_data;
    logic      take;
    logic      accept;

    assign take   = r_out_valid && !i_stall;
    assign accept = i_valid && !r_skid_valid;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out_data   = r_out_data;
        n_skid_data  = r_skid_data;
        if (r_skid_valid) begin
            if (take) begin
                n_out_data   = r_skid_data;
                n_skid_valid = 1'b0;
            end
        end else if (!r_out_valid || take) begin
            n_out_valid = accept;
            n_out_data  = i_data;
        end else if (accept) begin
            n_skid_valid = 1'b1;
            n_skid_data  = i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data  <= n_out_data;
        r_skid_data <= n_skid_data;
    end

    assign o_stall = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

endmodule

@@ rtl/core/gamepad_serial_poll_encoder.sv @@
// ----------------------------------------------------------------------------
// gamepad_serial_poll_encoder
// polls a shift-register game pad once a period and reports changed buttons
// ----------------------------------------------------------------------------
// a result is registered in the output register, or in the skid entry while the output is stalled
// throughput: one tick per cycle while the skid entry is empty and o_in_stall is low
// the one-entry skid holds a second result while the output is stalled
// synchronous active-low reset: phase idle, counters cleared, word 0x1111
// registers come out of reset at 50000, 12 and 6 ticks
module gamepad_serial_poll_encoder (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [gspe_pkg::CfgIdxW-1:0]    i_cfg_idx,
    input  logic [gspe_pkg::CfgDataW-1:0]   i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  gspe_pkg::t_in_item              i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output gspe_pkg::t_out_item             o_out_data
);
    import gspe_pkg::*;

    logic      step;
    logic      skid_stall;
    t_out_item seq_result;

    assign step       = i_in_valid && !skid_stall;
    assign o_in_stall = skid_stall;

    gspe_poll_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_step     (step),
        .i_item     (i_in_data),
        .o_result   (seq_result)
    );

    gspe_out_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (step),
        .i_data  (seq_result),
        .o_stall (skid_stall),
        .o_valid (o_out_valid),
        .o_data  (o_out_data),
        .i_stall (i_out_stall)
    );

endmodule

@@ tb/sv/tb_gamepad_serial_poll_encoder.sv @@
// ----------------------------------------------------------------------------
// tb_gamepad_serial_poll_encoder
// drives pad data and transmitter-ready ticks through the poll encoder under
// random bursts and output stalls, predicts latch, clock and button code
// levels for every tick and checks each output transaction against them
// ----------------------------------------------------------------------------
module tb_gamepad_serial_poll_encoder;
    timeunit 1ns;
    timeprecision 1ps;

    import gspe_pkg::*;

    localparam int                 CycleLimit   = 400000;
    localparam int                 HoldCycles   = 64;
    localparam int                 SettleCycles = 4;
    localparam int                 MaxReported  = 10;
    localparam logic [CfgIdxW-1:0] CfgIdxSpare  = 2'd3;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } t_stall_mode;

    class pad_read_scoreboard;
        logic [PollW-1:0]      poll_period;
        logic [LenW-1:0]       latch_len;
        logic [LenW-1:0]       half_len;
        logic [PollW-1:0]      poll_count;
        t_phase                phase;
        logic [LenW-1:0]       phase_count;
        logic [BitCntW-1:0]    bit_index;
        logic [ButtonBits-1:0] shift_word;
        logic [ButtonBits-1:0] last_word;
        int                    reads_done;
        int                    mismatches;
        t_out_item             expected_levels[$];

        function new();
            poll_period = PollPeriodReset;
            latch_len   = LatchReset;
            half_len    = HalfReset;
            poll_count  = '0;
            phase       = PH_IDLE;
            phase_count = '0;
            bit_index   = '0;
            shift_word  = '0;
            last_word   = LastWordReset;
            reads_done  = 0;
            mismatches  = 0;
        endfunction

        function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
            case (idx)
                CFG_POLL_PERIOD: poll_period = data;
                CFG_LATCH:       latch_len = data[LenW-1:0];
                CFG_HALF:        half_len = data[LenW-1:0];
                default: ;
            endcase
        endfunction

        function logic [CodeW-1:0] button_code(logic [ButtonBits-1:0] w);
            case (w)
                WordNone: return CodeNone;
                WordBtnA: return CodeBtnA;
                WordBtnB: return CodeBtnB;
                WordBtnC: return CodeBtnC;
                default:  return CodeOther;
            endcase
        endfunction

        // data level that makes the next sampled bit match the target word
        function logic next_pin(logic [ButtonBits-1:0] target);
            int idx;
            idx = (phase == PH_LOW) ? int'(bit_index) + 1 : int'(bit_index);
            if (idx >= ButtonBits) return 1'b1;
            return ~target[idx];
        endfunction

        function void note_tick(t_in_item it);
            t_out_item       r;
            logic            due;
            logic            take;
            logic [LenW-1:0] len;
            r    = '0;
            take = 1'b0;
            due  = ({1'b0, poll_count} + 17'd1) >= {1'b0, poll_period};
            len  = (phase == PH_LATCH) ? latch_len : half_len;
            if (phase != PH_IDLE && phase_count >= len) begin
                phase_count = '0;
                case (phase)
                    PH_LATCH: phase = PH_GAP;
                    PH_GAP: begin
                        phase = PH_HIGH;
                        take  = 1'b1;
                    end
                    PH_HIGH: phase = PH_LOW;
                    default: begin
                        bit_index = bit_index + 1'b1;
                        if (bit_index >= ButtonBits) begin
                            if (shift_word != last_word && it.tx_ready) begin
                                r.send_valid = 1'b1;
                                r.send_code  = button_code(shift_word);
                            end
                            last_word = shift_word;
                            phase     = PH_IDLE;
                            reads_done++;
                        end else begin
                            phase = PH_HIGH;
                            take  = 1'b1;
                        end
                    end
                endcase
            end
            if (take && !it.data_pin) shift_word[bit_index[BitIdxW-1:0]] = 1'b1;
            if (phase == PH_IDLE && due) begin
                phase       = PH_LATCH;
                phase_count = '0;
                bit_index   = '0;
                shift_word  = '0;
                poll_count  = '0;
            end else if (!due) begin
                poll_count = poll_count + 1'b1;
            end
            r.latch_out = (phase == PH_LATCH);
            r.clock_out = (phase == PH_HIGH);
            if (phase != PH_IDLE && phase_count != CountMax) phase_count++;
            expected_levels.push_back(r);
        endfunction

        function void check_tick(t_out_item got);
            t_out_item want;
            if (expected_levels.size() == 0) begin
                mismatches++;
                if (mismatches <= MaxReported)
                    $display("unexpected transaction: latch %b clock %b valid %b code %0d",
                             got.latch_out, got.clock_out, got.send_valid, got.send_code);
                return;
            end
            want = expected_levels.pop_front();
            if (want.latch_out !== got.latch_out || want.clock_out !== got.clock_out ||
                want.send_valid !== got.send_valid || want.send_code !== got.send_code) begin
                mismatches++;
                if (mismatches <= MaxReported)
                    $display("mismatch: expected latch %b clock %b valid %b code %0d, %s",
                             want.latch_out, want.clock_out, want.send_valid, want.send_code,
                             $sformatf("got latch %b clock %b valid %b code %0d",
                                       got.latch_out, got.clock_out, got.send_valid,
                                       got.send_code));
            end
        endfunction
    endclass

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_cfg_we    = 1'b0;
    logic [CfgIdxW-1:0]  i_cfg_idx   = '0;
    logic [CfgDataW-1:0] i_cfg_data  = '0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_stall;
    t_in_item            i_in_data   = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    t_out_item           o_out_data;

    pad_read_scoreboard  preds       = new();
    logic                in_taken    = 1'b0;
    bit                  hold_req    = 1'b0;
    int unsigned         cycles      = 0;

    gamepad_serial_poll_encoder i_dut (.*);

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("status: fail");
            $finish;
        end else begin
            in_taken = i_rst_n && i_in_valid && !o_in_stall;
            if (in_taken) preds.note_tick(i_in_data);
            if (i_rst_n && o_out_valid && !i_out_stall) preds.check_tick(o_out_data);
        end
    end

    initial begin : out_stall_gen
        t_stall_mode mode;
        int          span;
        mode = STALL_NONE;
        span = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (HoldCycles) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                if (span == 0) begin
                    mode = t_stall_mode'($urandom_range(0, 3));
                    span = $urandom_range(16, 80);
                end
                span--;
                case (mode)
                    STALL_NONE:  i_out_stall <= 1'b0;
                    STALL_LIGHT: i_out_stall <= ($urandom_range(0, 7) == 0);
                    STALL_HEAVY: i_out_stall <= 1'($urandom_range(0, 1));
                    default:     i_out_stall <= (span % 4 == 0);
                endcase
            end
        end
    end

    task automatic send_tick(input t_in_item it);
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(negedge i_clk);
        while (!in_taken) @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (preds.expected_levels.size() != 0) @(negedge i_clk);
        repeat (SettleCycles) @(negedge i_clk);
    endtask

    task automatic write_regs(input logic [CfgDataW-1:0] poll, input logic [CfgDataW-1:0] latch,
                              input logic [CfgDataW-1:0] half);
        logic [CfgIdxW-1:0]  idx_list [4];
        logic [CfgDataW-1:0] val_list [4];
        idx_list = '{CFG_POLL_PERIOD, CFG_LATCH, CFG_HALF, CfgIdxSpare};
        val_list = '{poll, latch, half, CfgDataW'($urandom)};
        for (int k = 0; k < 4; k++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idx_list[k];
            i_cfg_data <= val_list[k];
            @(negedge i_clk);
            preds.write_reg(idx_list[k], val_list[k]);
        end
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [ButtonBits-1:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return WordNone;
            1:       return WordBtnA;
            2:       return WordBtnB;
            3:       return WordBtnC;
            4, 5:    return preds.last_word;
            6:       return ButtonBits'(1) << $urandom_range(0, ButtonBits - 1);
            7:       return '1;
            default: return ButtonBits'($urandom);
        endcase
    endfunction

    // mostly pad words aimed at a chosen button pattern, with some line noise
    task automatic run_phase(input int min_ticks, input int min_reads);
        int                    ticks;
        int                    first_read;
        int                    seen_reads;
        int                    burst;
        int                    gap;
        logic [ButtonBits-1:0] target;
        t_in_item              it;
        ticks      = 0;
        first_read = preds.reads_done;
        seen_reads = preds.reads_done;
        burst      = 0;
        target     = pick_word();
        while (ticks < min_ticks || preds.reads_done - first_read < min_reads) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 24);
                gap   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                if (gap > 0) begin
                    i_in_valid <= 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
            end
            if (preds.reads_done != seen_reads) begin
                seen_reads = preds.reads_done;
                target     = pick_word();
            end
            it.data_pin = ($urandom_range(0, 11) == 0) ? 1'($urandom) : preds.next_pin(target);
            it.tx_ready = ($urandom_range(0, 4) != 0);
            send_tick(it);
            burst--;
            ticks++;
        end
    endtask

    task automatic run_setting(input logic [PollW-1:0] poll, input logic [LenW-1:0] latch,
                               input logic [LenW-1:0] half, input int min_ticks,
                               input int min_reads);
        write_regs(poll, {8'($urandom), latch}, {8'($urandom), half});
        run_phase(min_ticks, min_reads);
        drain();
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings, every data and ready level
        for (int k = 0; k < 4; k++) send_tick(t_in_item'(2'(k)));
        drain();

        // zero lengths and back-to-back reads
        hold_req = 1'b1;
        run_setting(16'd0, 8'd0, 8'd0, 0, 3);
        run_setting(16'd1, 8'd1, 8'd1, 0, 2);
        hold_req = 1'b1;
        run_setting(16'd50, 8'd2, 8'd1, 0, 2);
        // read longer than the poll period
        run_setting(16'd20, 8'd5, 8'd1, 0, 2);
        // long clock halves, then shortened in the middle of the read
        run_setting(16'd0, 8'd1, 8'd60, 80, 0);
        run_setting(16'd0, 8'd1, 8'd1, 0, 1);
        run_setting(PollW'($urandom_range(30, 60)), LenW'($urandom_range(1, 8)),
                    LenW'($urandom_range(1, 2)), 0, 1);
        run_setting(16'd65535, 8'd12, 8'd6, 40, 0);

        preds.mismatches += preds.expected_levels.size();
        if (preds.mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
